### rtl/core/pcsc_pkg.sv
`default_nettype none
package pcsc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_W     = 32;
  localparam int DIV_CELLS = NUM_W;
  localparam logic [31:0] HALF_RATIO = 32'h0000_8000;

  localparam logic [15:0] RST_SCREEN_W = 16'd1920;
  localparam logic [15:0] RST_SCREEN_H = 16'd1080;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_LAYOUT = 2'd1;
  localparam logic [1:0] ST_BAD_SCALE = 2'd2;

  localparam logic [1:0] LAYOUT_LINEAR = 2'd0;
  localparam logic [1:0] LAYOUT_TILED  = 2'd1;

  localparam logic [2:0] REG_SCREEN_W  = 3'd0;
  localparam logic [2:0] REG_SCREEN_H  = 3'd1;
  localparam logic [2:0] REG_CAN_SCALE = 3'd2;
  localparam logic [2:0] REG_CAN_DBL   = 3'd3;
  localparam logic [2:0] REG_CAN_TILE  = 3'd4;

  // Data handed from one divider cell to the next.
  typedef struct packed {
    logic [15:0] rem_h;
    logic [15:0] rem_v;
    logic [31:0] num_h;
    logic [31:0] num_v;
    logic [31:0] q_h;
    logic [31:0] q_v;
    logic [15:0] den_h;
    logic [15:0] den_v;
    logic [15:0] aw;
    logic [15:0] ah;
    logic [14:0] ox;
    logic [14:0] oy;
    logic [15:0] hx;
    logic [15:0] hy;
    logic [15:0] sx;
    logic [15:0] sy;
    logic        bad_layout;
  } cell_t;

  // Visible length of a span of length n starting at s on a screen of size l.
  function automatic logic [15:0] visible_len(logic signed [15:0] s, logic [15:0] n,
                                              logic [15:0] l);
    logic signed [17:0] e;
    logic [15:0] room;
    logic [15:0] res;
    e    = {{2{s[15]}}, s} + {2'b00, n};
    room = l - s;
    if (s[15] || (s == 16'sd0)) begin
      if (!e[17] && (e != 18'sd0)) begin
        res = (e[16:0] < {1'b0, l}) ? e[15:0] : l;
      end else begin
        res = 16'd0;
      end
    end else if (s <= $signed({1'b0, l[14:0]}) || l[15]) begin
      res = (room < n) ? room : n;
    end else begin
      res = 16'd0;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### rtl/core/pcsc_div_cell.sv
`default_nettype none
module pcsc_div_cell
  import pcsc_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   v_in,
  input  cell_t d_in,
  input  wire   hold_in,
  output logic  hold_out,
  output logic  v_out,
  output cell_t d_out
);

  logic  v_r;
  cell_t d_r;
  cell_t d_nxt;
  logic [16:0] th;
  logic [16:0] tv;
  logic qh;
  logic qv;

  // One restoring step per axis: bring down the next dividend bit, subtract if it fits.
  always_comb begin
    d_nxt = d_in;
    th = {d_in.rem_h, d_in.num_h[31]};
    tv = {d_in.rem_v, d_in.num_v[31]};
    qh = (th >= {1'b0, d_in.den_h});
    qv = (tv >= {1'b0, d_in.den_v});
    if (qh) th = th - {1'b0, d_in.den_h};
    if (qv) tv = tv - {1'b0, d_in.den_v};
    d_nxt.rem_h = th[15:0];
    d_nxt.rem_v = tv[15:0];
    d_nxt.num_h = {d_in.num_h[30:0], 1'b0};
    d_nxt.num_v = {d_in.num_v[30:0], 1'b0};
    d_nxt.q_h   = {d_in.q_h[30:0], qh};
    d_nxt.q_v   = {d_in.q_v[30:0], qv};
  end

  assign hold_out = v_r & hold_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!hold_out) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold_out) begin
      d_r <= d_nxt;
    end
  end

  assign v_out = v_r;
  assign d_out = d_r;

endmodule
`default_nettype wire

### rtl/core/pcsc_tail.sv
`default_nettype none
module pcsc_tail
  import pcsc_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          v_in,
  input  cell_t        d_in,
  output logic         hold_out,
  input  wire          can_scale,
  input  wire          can_double,
  input  wire          out_stall,
  output logic         out_valid,
  output logic [31:0]  out_h_ratio,
  output logic [31:0]  out_v_ratio,
  output logic [16:0]  out_src_x,
  output logic [16:0]  out_src_y,
  output logic [15:0]  out_src_w,
  output logic [15:0]  out_src_h,
  output logic [14:0]  out_dst_x,
  output logic [14:0]  out_dst_y,
  output logic [15:0]  out_dst_w,
  output logic [15:0]  out_dst_h,
  output logic [1:0]   out_status
);

  logic        vm_r;
  logic        hold_m;
  logic        hold_o;
  logic [31:0] pw_r, ph_r, px_r, py_r;
  logic [31:0] hr_r, vr_r;
  cell_t       dm_r;
  logic        vo_r;
  logic [15:0] ow, oh;
  logic        wok, hok;
  logic [1:0]  st;

  assign hold_o   = vo_r & out_stall;
  assign hold_m   = vm_r & hold_o;
  assign hold_out = hold_m;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (!hold_m) vm_r <= v_in;
      if (!hold_o) vo_r <= vm_r;
    end
  end

  // Products wrap at 32 bits; only the upper half is used.
  always_ff @(posedge clk) begin
    if (!hold_m) begin
      pw_r <= 32'(d_in.aw * d_in.q_h);
      ph_r <= 32'(d_in.ah * d_in.q_v);
      px_r <= 32'(d_in.hx * d_in.q_h);
      py_r <= 32'(d_in.hy * d_in.q_v);
      hr_r <= d_in.q_h;
      vr_r <= d_in.q_v;
      dm_r <= d_in;
    end
  end

  always_comb begin
    ow  = pw_r[31:16];
    oh  = ph_r[31:16];
    wok = (ow == dm_r.aw) || (can_double && (hr_r == HALF_RATIO));
    hok = (oh == dm_r.ah) || (can_double && (vr_r == HALF_RATIO));
    if (dm_r.bad_layout) st = ST_BAD_LAYOUT;
    else if (!can_scale && !(wok && hok)) st = ST_BAD_SCALE;
    else st = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!hold_o) begin
      out_h_ratio <= hr_r;
      out_v_ratio <= vr_r;
      out_src_x   <= {1'b0, dm_r.sx} + {1'b0, px_r[31:16]};
      out_src_y   <= {1'b0, dm_r.sy} + {1'b0, py_r[31:16]};
      out_src_w   <= ow;
      out_src_h   <= oh;
      out_dst_x   <= dm_r.ox;
      out_dst_y   <= dm_r.oy;
      out_dst_w   <= dm_r.aw;
      out_dst_h   <= dm_r.ah;
      out_status  <= st;
    end
  end

  assign out_valid = vo_r;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && out_stall) |=> vo_r) else $error("stalled result dropped");
  a_mul_hold: assert property (@(posedge clk) disable iff (!rst_n)
    hold_m |=> vm_r) else $error("multiply stage lost a request");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r |-> (out_status != 2'd3)) else $error("status code out of range");
  a_stat_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && out_stall) |=> $stable(out_status) && $stable(out_h_ratio))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

### rtl/core/plane_clip_and_scale_check.sv
`default_nettype none
// Plane clip and scale check.
// Input channel (in_*): one plane request per accepted beat, taken at a rising edge with
// in_valid high and in_stall low. Result channel (out_*): one result per request, in
// order, taken when out_valid is high and out_stall low.
// Each request passes a row of 32 divider cells, one quotient bit per cell for both
// ratios, then a multiply stage and an output register. One request is accepted every
// cycle while nothing stalls; the rate is set by the cell row, where every cell
// advances each cycle unless it is full and its successor holds.
// When the receiver stalls, the output register holds its result and each stage
// behind it holds only when it is full and its successor holds, so empty slots
// are still filled and in_stall rises only when the whole row is full.
// Reset (rst_n low at a clock edge) empties all stages and loads the register
// defaults: 1920 x 1080 screen, scaling, doubling and tiling disabled.
// Registers are written through the APB port at byte addresses 0, 4, 8, 12, 16 and
// must only be changed while no request is in flight.
module plane_clip_and_scale_check
  import pcsc_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_valid,
  output logic         in_stall,
  input  wire  [15:0]  in_dst_x,
  input  wire  [15:0]  in_dst_y,
  input  wire  [15:0]  in_dst_w,
  input  wire  [15:0]  in_dst_h,
  input  wire  [15:0]  in_src_left,
  input  wire  [15:0]  in_src_top,
  input  wire  [15:0]  in_src_width,
  input  wire  [15:0]  in_src_height,
  input  wire  [1:0]   in_buffer_layout,
  output logic         out_valid,
  input  wire          out_stall,
  output logic [31:0]  out_h_ratio,
  output logic [31:0]  out_v_ratio,
  output logic [16:0]  out_src_x,
  output logic [16:0]  out_src_y,
  output logic [15:0]  out_src_w,
  output logic [15:0]  out_src_h,
  output logic [14:0]  out_dst_x,
  output logic [14:0]  out_dst_y,
  output logic [15:0]  out_dst_w,
  output logic [15:0]  out_dst_h,
  output logic [1:0]   out_status,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [4:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [15:0] screen_w_r, screen_h_r;
  logic        can_scale_r, can_double_r, can_tile_r;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // Register file, written on the access phase of an APB write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r   <= RST_SCREEN_W;
      screen_h_r   <= RST_SCREEN_H;
      can_scale_r  <= 1'b0;
      can_double_r <= 1'b0;
      can_tile_r   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_SCREEN_W:  screen_w_r   <= pwdata[15:0];
        REG_SCREEN_H:  screen_h_r   <= pwdata[15:0];
        REG_CAN_SCALE: can_scale_r  <= pwdata[0];
        REG_CAN_DBL:   can_double_r <= pwdata[0];
        REG_CAN_TILE:  can_tile_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCREEN_W:  prdata = {16'd0, screen_w_r};
      REG_SCREEN_H:  prdata = {16'd0, screen_h_r};
      REG_CAN_SCALE: prdata = {31'd0, can_scale_r};
      REG_CAN_DBL:   prdata = {31'd0, can_double_r};
      REG_CAN_TILE:  prdata = {31'd0, can_tile_r};
      default:       prdata = 32'd0;
    endcase
  end

  // Request preparation: clip the destination to the screen and set up both divisions.
  cell_t head;
  logic [15:0] aw, ah;

  always_comb begin
    aw = visible_len($signed(in_dst_x), in_dst_w, screen_w_r);
    ah = visible_len($signed(in_dst_y), in_dst_h, screen_h_r);
    head = '0;
    head.num_h = {in_src_width, 16'd0};
    head.num_v = {in_src_height, 16'd0};
    head.den_h = in_dst_w;
    head.den_v = in_dst_h;
    head.aw    = aw;
    head.ah    = ah;
    head.ox    = in_dst_x[15] ? 15'd0 : in_dst_x[14:0];
    head.oy    = in_dst_y[15] ? 15'd0 : in_dst_y[14:0];
    // The hidden part only moves the source origin when something stays visible.
    head.hx    = (in_dst_x[15] && (aw != 16'd0)) ? (~in_dst_x + 16'd1) : 16'd0;
    head.hy    = (in_dst_y[15] && (ah != 16'd0)) ? (~in_dst_y + 16'd1) : 16'd0;
    head.sx    = in_src_left;
    head.sy    = in_src_top;
    head.bad_layout = in_buffer_layout[1] ||
                      ((in_buffer_layout == LAYOUT_TILED) && !can_tile_r);
  end

  cell_t chain [0:DIV_CELLS];
  logic  vch   [0:DIV_CELLS];
  logic  hch   [0:DIV_CELLS];

  assign chain[0] = head;
  assign vch[0]   = in_valid;
  assign in_stall = hch[0];

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    pcsc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .v_in     (vch[i]),
      .d_in     (chain[i]),
      .hold_in  (hch[i+1]),
      .hold_out (hch[i]),
      .v_out    (vch[i+1]),
      .d_out    (chain[i+1])
    );
  end

  pcsc_tail u_tail (
    .clk         (clk),
    .rst_n       (rst_n),
    .v_in        (vch[DIV_CELLS]),
    .d_in        (chain[DIV_CELLS]),
    .hold_out    (hch[DIV_CELLS]),
    .can_scale   (can_scale_r),
    .can_double  (can_double_r),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_h_ratio (out_h_ratio),
    .out_v_ratio (out_v_ratio),
    .out_src_x   (out_src_x),
    .out_src_y   (out_src_y),
    .out_src_w   (out_src_w),
    .out_src_h   (out_src_h),
    .out_dst_x   (out_dst_x),
    .out_dst_y   (out_dst_y),
    .out_dst_w   (out_dst_w),
    .out_dst_h   (out_dst_h),
    .out_status  (out_status)
  );

endmodule
`default_nettype wire
